// ===== design/bpsd_pkg.sv =====
// shared types and constants for the bmp 24-bit pixel stream decoder
`timescale 1ns / 1ps

package bpsd_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] SIG_BYTE0 = 8'h42;
  localparam logic [7:0] SIG_BYTE1 = 8'h4d;

  localparam logic [31:0] HDR_OFFSET_POS = 32'd10;
  localparam logic [31:0] HDR_WIDTH_POS  = 32'd18;
  localparam logic [31:0] HDR_HEIGHT_POS = 32'd22;
  localparam logic [31:0] HDR_BPP_POS    = 32'd28;
  localparam logic [31:0] HDR_LAST       = 32'd53;
  localparam logic [15:0] BPP_SUPPORTED  = 16'd24;

  localparam logic [1:0] STAT_PIXEL     = 2'd0;
  localparam logic [1:0] STAT_BAD_SIG   = 2'd1;
  localparam logic [1:0] STAT_BAD_DEPTH = 2'd2;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd3;

  localparam logic [1:0] FMT_RGB565 = 2'd0;
  localparam logic [1:0] FMT_RGB888 = 2'd1;
  localparam logic [1:0] FMT_XRGB   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] pixel_value;
    logic [11:0] dest_row;
    logic [11:0] dest_col;
    logic        last_pixel;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [11:0] col;
    logic        last;
  } event_t;

endpackage

// ===== design/bpsd_front.sv =====
// front end: header parse, offset skip, pixel gathering and row/column tracking
`timescale 1ns / 1ps

module bpsd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  bpsd_pkg::in_beat_t in_beat,
  output logic               evt_valid,
  output bpsd_pkg::event_t   evt
);

  bpsd_pkg::phase_t phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [1:0]  pad_remaining, pad_remaining_next;
  logic [11:0] column_count, column_count_next;
  logic [11:0] row_count, row_count_next;

  logic [31:0] pixel_offset;
  logic [31:0] image_width;
  logic [31:0] image_height_raw;
  logic [15:0] bit_count;
  logic [7:0]  held_blue;
  logic [7:0]  held_green;
  logic [bpsd_pkg::DIM_W-1:0] width_dim;
  logic [bpsd_pkg::DIM_W-1:0] height_dim;
  logic        flip_rows;

  // state as seen by this beat, a start beat restarts the phase and all counters
  logic               sof;
  logic [7:0]         b;
  bpsd_pkg::phase_t   phase_e;
  logic [31:0]        pos_e;
  logic [1:0]         bip_e;
  logic [1:0]         pad_e;
  logic [11:0]        col_e;
  logic [11:0]        row_e;

  logic [31:0] height_mag;
  logic        in_header, sig_bad, hdr_last, err_depth, err_size, img_empty;
  logic        pixel_mode, pix_done, col_end, row_end;
  logic [bpsd_pkg::DIM_W-1:0] row_flip;

  assign sof     = in_beat.start_of_file;
  assign b       = in_beat.data_byte;
  assign phase_e = sof ? bpsd_pkg::PH_HEADER : phase;
  assign pos_e   = sof ? 32'd0 : byte_position;
  assign bip_e   = sof ? 2'd0 : byte_in_pixel;
  assign pad_e   = sof ? 2'd0 : pad_remaining;
  assign col_e   = sof ? 12'd0 : column_count;
  assign row_e   = sof ? 12'd0 : row_count;

  // classification of the beat
  always_comb begin
    height_mag = image_height_raw[31] ? (32'd0 - image_height_raw) : image_height_raw;
    in_header  = (phase_e == bpsd_pkg::PH_HEADER);
    sig_bad    = in_header && (((pos_e == 32'd0) && (b != bpsd_pkg::SIG_BYTE0)) ||
                               ((pos_e == 32'd1) && (b != bpsd_pkg::SIG_BYTE1)));
    hdr_last   = in_header && !sig_bad && (pos_e == bpsd_pkg::HDR_LAST);
    err_depth  = hdr_last && (bit_count != bpsd_pkg::BPP_SUPPORTED);
    err_size   = hdr_last && !err_depth &&
                 ((image_width > 32'(bpsd_pkg::MAX_DIM)) ||
                  (height_mag > 32'(bpsd_pkg::MAX_DIM)));
    img_empty  = hdr_last && !err_depth && !err_size &&
                 ((image_width == 32'd0) || (height_mag == 32'd0));
    pixel_mode = (phase_e == bpsd_pkg::PH_PIXEL) ||
                 ((phase_e == bpsd_pkg::PH_SKIP) && !(pos_e < pixel_offset));
    pix_done   = pixel_mode && (pad_e == 2'd0) && (bip_e == 2'd2);
    col_end    = ({1'b0, col_e} + 13'd1) >= width_dim;
    row_end    = ({1'b0, row_e} + 13'd1) >= height_dim;
    row_flip   = height_dim - 13'd1 - {1'b0, row_e};
  end

  // next phase
  always_comb begin
    phase_next = phase_e;
    unique case (phase_e)
      bpsd_pkg::PH_HEADER: begin
        if (sig_bad || err_depth || err_size || img_empty) begin
          phase_next = bpsd_pkg::PH_HALT;
        end else if (hdr_last) begin
          phase_next = bpsd_pkg::PH_SKIP;
        end
      end
      bpsd_pkg::PH_SKIP, bpsd_pkg::PH_PIXEL: begin
        if (pix_done && col_end && row_end) begin
          phase_next = bpsd_pkg::PH_HALT;
        end else if (pixel_mode) begin
          phase_next = bpsd_pkg::PH_PIXEL;
        end
      end
      bpsd_pkg::PH_IDLE, bpsd_pkg::PH_HALT: phase_next = phase_e;
      default: phase_next = bpsd_pkg::PH_IDLE;
    endcase
  end

  // counters and result beat
  always_comb begin
    byte_position_next = pos_e;
    byte_in_pixel_next = bip_e;
    pad_remaining_next = pad_e;
    column_count_next  = col_e;
    row_count_next     = row_e;
    evt_valid          = 1'b0;
    evt                = '0;
    if (in_header && !sig_bad) begin
      byte_position_next = pos_e + 32'd1;
    end
    if (sig_bad) begin
      evt_valid  = 1'b1;
      evt.status = bpsd_pkg::STAT_BAD_SIG;
    end else if (err_depth) begin
      evt_valid  = 1'b1;
      evt.status = bpsd_pkg::STAT_BAD_DEPTH;
    end else if (err_size) begin
      evt_valid  = 1'b1;
      evt.status = bpsd_pkg::STAT_TOO_LARGE;
    end
    if ((phase_e == bpsd_pkg::PH_SKIP) && !pixel_mode) begin
      byte_position_next = pos_e + 32'd1;
    end
    if (pixel_mode) begin
      if (pad_e != 2'd0) begin
        pad_remaining_next = pad_e - 2'd1;
      end else begin
        case (bip_e)
          2'd0:    byte_in_pixel_next = 2'd1;
          2'd1:    byte_in_pixel_next = 2'd2;
          default: begin
            byte_in_pixel_next = 2'd0;
            evt_valid  = 1'b1;
            evt.status = bpsd_pkg::STAT_PIXEL;
            evt.red    = b;
            evt.green  = held_green;
            evt.blue   = held_blue;
            evt.col    = col_e;
            evt.row    = flip_rows ? row_flip[11:0] : row_e;
            if (col_end) begin
              column_count_next  = 12'd0;
              pad_remaining_next = width_dim[1:0];
              if (row_end) begin
                evt.last = 1'b1;
              end else begin
                row_count_next = row_e + 12'd1;
              end
            end else begin
              column_count_next = col_e + 12'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bpsd_pkg::PH_IDLE;
      byte_position <= '0;
      byte_in_pixel <= '0;
      pad_remaining <= '0;
      column_count  <= '0;
      row_count     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      byte_in_pixel <= byte_in_pixel_next;
      pad_remaining <= pad_remaining_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
    end
  end

  // header fields and held pixel bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_header) begin
        if ((pos_e >= bpsd_pkg::HDR_OFFSET_POS) && (pos_e < bpsd_pkg::HDR_OFFSET_POS + 32'd4))
        begin
          pixel_offset[8*(2'(pos_e - bpsd_pkg::HDR_OFFSET_POS)) +: 8] <= b;
        end
        if ((pos_e >= bpsd_pkg::HDR_WIDTH_POS) && (pos_e < bpsd_pkg::HDR_WIDTH_POS + 32'd4))
        begin
          image_width[8*(2'(pos_e - bpsd_pkg::HDR_WIDTH_POS)) +: 8] <= b;
        end
        if ((pos_e >= bpsd_pkg::HDR_HEIGHT_POS) && (pos_e < bpsd_pkg::HDR_HEIGHT_POS + 32'd4))
        begin
          image_height_raw[8*(2'(pos_e - bpsd_pkg::HDR_HEIGHT_POS)) +: 8] <= b;
        end
        if ((pos_e >= bpsd_pkg::HDR_BPP_POS) && (pos_e < bpsd_pkg::HDR_BPP_POS + 32'd2))
        begin
          bit_count[8*(1'(pos_e - bpsd_pkg::HDR_BPP_POS)) +: 8] <= b;
        end
        if (hdr_last) begin
          width_dim  <= image_width[bpsd_pkg::DIM_W-1:0];
          height_dim <= height_mag[bpsd_pkg::DIM_W-1:0];
          flip_rows  <= !image_height_raw[31];
        end
      end
      if (pixel_mode && (pad_e == 2'd0)) begin
        if (bip_e == 2'd0) begin
          held_blue <= b;
        end
        if (bip_e == 2'd1) begin
          held_green <= b;
        end
      end
    end
  end

endmodule

// ===== design/bpsd_fifo.sv =====
// short event queue between the front end and the output stage
`timescale 1ns / 1ps

module bpsd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  bpsd_pkg::event_t wr_data,
  input  logic             rd,
  output bpsd_pkg::event_t rd_data,
  output logic             full,
  output logic             empty
);

  bpsd_pkg::event_t mem [bpsd_pkg::FIFO_DEPTH];
  logic [bpsd_pkg::FIFO_AW-1:0] wr_ptr;
  logic [bpsd_pkg::FIFO_AW-1:0] rd_ptr;
  logic [bpsd_pkg::FIFO_AW:0]   count;
  logic do_wr, do_rd;

  assign full    = (count == (bpsd_pkg::FIFO_AW+1)'(bpsd_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/bpsd_back.sv =====
// back end: format register, pixel conversion and output register
`timescale 1ns / 1ps

module bpsd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_data,
  input  logic                evt_avail,
  input  bpsd_pkg::event_t    evt,
  output logic                evt_take,
  output logic                out_valid,
  output bpsd_pkg::out_beat_t out_beat,
  input  logic                pop
);

  logic [1:0] out_format;
  bpsd_pkg::out_beat_t conv;

  assign evt_take = evt_avail && (!out_valid || pop);

  always_comb begin
    conv.status     = evt.status;
    conv.dest_row   = evt.row;
    conv.dest_col   = evt.col;
    conv.last_pixel = evt.last;
    if (out_format == bpsd_pkg::FMT_RGB565) begin
      conv.pixel_value = {8'd0, evt.red[7:3], evt.green[7:2], evt.blue[7:3]};
    end else begin
      conv.pixel_value = {evt.red, evt.green, evt.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_format <= bpsd_pkg::FMT_RGB565;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        out_format <= cfg_data;
      end
      if (evt_take) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      out_beat <= conv;
    end
  end

endmodule

// ===== design/bmp24_pixel_stream_decoder.sv =====
// top level of the bmp 24-bit pixel stream decoder
//
//   channel   handshake            payload
//   input     push / full          in_beat  (data_byte, start_of_file)
//   result    pop / empty          out_beat (status, pixel_value, dest_row, dest_col, last_pixel)
//   config    cfg_valid/cfg_ready  cfg_data (out_format)
//
// one byte per cycle while full is low; a result passes through the event queue and the output register
// the four-entry event queue plus the output register absorb result stalls
// full rises only when the queue is full; cfg_ready is always high
// synchronous reset clears the parser to idle and the format to rgb565
`timescale 1ns / 1ps

module bmp24_pixel_stream_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  bpsd_pkg::in_beat_t  in_beat,
  output logic                empty,
  input  logic                pop,
  output bpsd_pkg::out_beat_t out_beat,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);

  logic             in_accept;
  logic             evt_valid;
  bpsd_pkg::event_t evt_in;
  bpsd_pkg::event_t evt_out;
  logic             q_full, q_empty, evt_take, out_valid;

  assign full      = q_full;
  assign in_accept = push && !q_full;
  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  bpsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .in_beat   (in_beat),
    .evt_valid (evt_valid),
    .evt       (evt_in)
  );

  bpsd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (in_accept && evt_valid),
    .wr_data (evt_in),
    .rd      (evt_take),
    .rd_data (evt_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  bpsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .evt_avail (!q_empty),
    .evt       (evt_out),
    .evt_take  (evt_take),
    .out_valid (out_valid),
    .out_beat  (out_beat),
    .pop       (pop)
  );

endmodule
